>>> rtl/alp_pkg.sv
package alp_pkg;

    // offsets after the guard shift, products and rotated sums
    localparam int D_W       = 33;
    localparam int TRIG_W    = 16;
    localparam int P_W       = D_W + TRIG_W;
    localparam int X_W       = P_W + 1;
    // cordic datapath, room for the gain of two passes
    localparam int CW        = 56;
    localparam int TURN_W    = 32;
    localparam int TABLE_LEN = 24;
    localparam int CFG_IDX_W = 3;

    // cordic gain 1.64676 in q14
    localparam logic signed [TRIG_W:0] GAIN_Q14 = 17'sd26981;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POI_NORTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POI_EAST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POI_DOWN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AZ_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AZ_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EL_LOWER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EL_UPPER  = 3'd6;

    typedef logic signed [CW-1:0] t_vec;
    typedef logic [TURN_W-1:0]    t_turn;

    // arctangent of 2^-i as a fraction of a full turn
    function automatic t_turn atan_turn(input int unsigned step);
        t_turn r;
        case (step)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/alp_in_if.sv
interface alp_in_if #(
    parameter int POS_WIDTH   = 32,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [POS_WIDTH-1:0]   own_north;
    logic signed [POS_WIDTH-1:0]   own_east;
    logic signed [POS_WIDTH-1:0]   own_down;
    logic signed [15:0]            heading_sine;
    logic signed [15:0]            heading_cosine;
    logic [ANGLE_WIDTH-2:0]        scan_width;
    logic [ANGLE_WIDTH-2:0]        scan_height;

    modport source (
        output valid, own_north, own_east, own_down, heading_sine, heading_cosine,
               scan_width, scan_height,
        input  ready
    );
    modport sink (
        input  valid, own_north, own_east, own_down, heading_sine, heading_cosine,
               scan_width, scan_height,
        output ready
    );
endinterface

>>> rtl/alp_out_if.sv
interface alp_out_if #(
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] ref_azimuth;
    logic signed [ANGLE_WIDTH-1:0] ref_elevation;

    modport source (output valid, ref_azimuth, ref_elevation, input ready);
    modport sink   (input valid, ref_azimuth, ref_elevation, output ready);
endinterface

>>> rtl/alp_front.sv
module alp_front #(
    parameter int POS_WIDTH   = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    alp_in_if.sink                          i_in,
    input  logic signed [POS_WIDTH-1:0]     i_poi_north,
    input  logic signed [POS_WIDTH-1:0]     i_poi_east,
    input  logic signed [POS_WIDTH-1:0]     i_poi_down,
    output logic                            o_valid,
    input  logic                            i_ready,
    output alp_pkg::t_vec                   o_x,
    output alp_pkg::t_vec                   o_y,
    output alp_pkg::t_turn                  o_ang,
    output logic signed [alp_pkg::X_W-1:0]  o_h,
    output logic                            o_az_zero,
    output logic [ANGLE_WIDTH-2:0]          o_swid,
    output logic [ANGLE_WIDTH-2:0]          o_shgt
);
    import alp_pkg::*;

    localparam int DIFF_W = POS_WIDTH + 1;
    localparam int GUARD  = (POS_WIDTH > 32) ? (POS_WIDTH - 32) : 0;

    logic                     w_en1, w_en2, w_en3;
    logic signed [DIFF_W-1:0] w_dn_full, w_de_full, w_dd_full;
    logic signed [X_W-1:0]    w_sx, w_sy;
    t_vec                     w_x, w_y;

    logic                     r1_valid;
    logic signed [D_W-1:0]    r1_dn, r1_de, r1_dd;
    logic signed [TRIG_W-1:0] r1_sn, r1_cs;
    logic [ANGLE_WIDTH-2:0]   r1_sw, r1_sh;

    logic                     r2_valid;
    logic signed [P_W-1:0]    r2_pnc, r2_pes, r2_pec, r2_pns, r2_pdg;
    logic [ANGLE_WIDTH-2:0]   r2_sw, r2_sh;

    logic                     r3_valid;
    t_vec                     r3_x, r3_y;
    t_turn                    r3_ang;
    logic signed [X_W-1:0]    r3_h;
    logic                     r3_az_zero;
    logic [ANGLE_WIDTH-2:0]   r3_sw, r3_sh;

    // stage advance, bubbles collapse
    assign w_en3      = !r3_valid || i_ready;
    assign w_en2      = !r2_valid || w_en3;
    assign w_en1      = !r1_valid || w_en2;
    assign i_in.ready = w_en1;

    // offsets to the point of interest
    assign w_dn_full = DIFF_W'(i_poi_north) - DIFF_W'(i_in.own_north);
    assign w_de_full = DIFF_W'(i_poi_east)  - DIFF_W'(i_in.own_east);
    assign w_dd_full = DIFF_W'(i_poi_down)  - DIFF_W'(i_in.own_down);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en1) begin
            r1_valid <= i_in.valid;
        end
        if (w_en1) begin
            r1_dn <= D_W'(w_dn_full >>> GUARD);
            r1_de <= D_W'(w_de_full >>> GUARD);
            r1_dd <= D_W'(w_dd_full >>> GUARD);
            r1_sn <= i_in.heading_sine;
            r1_cs <= i_in.heading_cosine;
            r1_sw <= i_in.scan_width;
            r1_sh <= i_in.scan_height;
        end
    end

    // heading products and height gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en2) begin
            r2_valid <= r1_valid;
        end
        if (w_en2) begin
            r2_pnc <= r1_dn * r1_cs;
            r2_pes <= r1_de * r1_sn;
            r2_pec <= r1_de * r1_cs;
            r2_pns <= r1_dn * r1_sn;
            r2_pdg <= r1_dd * GAIN_Q14;
            r2_sw  <= r1_sw;
            r2_sh  <= r1_sh;
        end
    end

    // rotated sums and rear hemisphere fold
    assign w_sx = X_W'(r2_pnc) + X_W'(r2_pes);
    assign w_sy = X_W'(r2_pec) - X_W'(r2_pns);
    assign w_x  = CW'(w_sx);
    assign w_y  = CW'(w_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en3) begin
            r3_valid <= r2_valid;
        end
        if (w_en3) begin
            r3_x       <= w_sx[X_W-1] ? -w_x : w_x;
            r3_y       <= w_sx[X_W-1] ? -w_y : w_y;
            r3_ang     <= w_sx[X_W-1] ? {1'b1, {(TURN_W-1){1'b0}}} : '0;
            r3_h       <= -X_W'(r2_pdg);
            r3_az_zero <= (w_sx == '0) && (w_sy == '0);
            r3_sw      <= r2_sw;
            r3_sh      <= r2_sh;
        end
    end

    assign o_valid   = r3_valid;
    assign o_x       = r3_x;
    assign o_y       = r3_y;
    assign o_ang     = r3_ang;
    assign o_h       = r3_h;
    assign o_az_zero = r3_az_zero;
    assign o_swid    = r3_sw;
    assign o_shgt    = r3_sh;

endmodule

>>> rtl/alp_cordic_stage.sv
module alp_cordic_stage #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  alp_pkg::t_vec        i_x,
    input  alp_pkg::t_vec        i_y,
    input  alp_pkg::t_turn       i_ang,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output alp_pkg::t_vec        o_x,
    output alp_pkg::t_vec        o_y,
    output alp_pkg::t_turn       o_ang,
    output logic [SIDE_W-1:0]    o_side
);
    import alp_pkg::*;

    logic              w_en;
    t_vec              w_dx, w_dy;
    logic              r_valid;
    t_vec              r_x, r_y;
    t_turn             r_ang;
    logic [SIDE_W-1:0] r_side;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign w_dx    = i_y >>> STEP;
    assign w_dy    = i_x >>> STEP;

    // one vectoring rotation toward y = 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
        if (w_en) begin
            if (!i_y[CW-1]) begin
                r_x   <= i_x + w_dx;
                r_y   <= i_y - w_dy;
                r_ang <= i_ang + atan_turn(STEP);
            end else begin
                r_x   <= i_x - w_dx;
                r_y   <= i_y + w_dy;
                r_ang <= i_ang - atan_turn(STEP);
            end
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_ang   = r_ang;
    assign o_side  = r_side;

endmodule

>>> rtl/alp_limit.sv
module alp_limit #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  alp_pkg::t_turn         i_az_turns,
    input  alp_pkg::t_turn         i_el_turns,
    input  logic                   i_el_zero,
    input  logic [ANGLE_WIDTH-2:0] i_swid,
    input  logic [ANGLE_WIDTH-2:0] i_shgt,
    input  logic [ANGLE_WIDTH-1:0] i_az_left,
    input  logic [ANGLE_WIDTH-1:0] i_az_right,
    input  logic [ANGLE_WIDTH-1:0] i_el_lower,
    input  logic [ANGLE_WIDTH-1:0] i_el_upper,
    alp_out_if.source              o_out
);
    import alp_pkg::*;

    localparam t_turn HALF_LSB = t_turn'(1) << (TURN_W - 1 - ANGLE_WIDTH);

    logic                          w_en;
    t_turn                         w_az_rnd, w_el_rnd;
    logic signed [ANGLE_WIDTH-1:0] w_az, w_el;
    logic [ANGLE_WIDTH-1:0]        w_hw, w_hh;
    logic signed [ANGLE_WIDTH-1:0] w_az_lo, w_az_hi, w_el_lo, w_el_hi;
    logic signed [ANGLE_WIDTH-1:0] n_az, n_el;
    logic                          r_valid;
    logic signed [ANGLE_WIDTH-1:0] r_az, r_el;

    assign w_en    = !r_valid || o_out.ready;
    assign o_ready = w_en;

    // round half up to the output angle width
    assign w_az_rnd = i_az_turns + HALF_LSB;
    assign w_el_rnd = i_el_turns + HALF_LSB;
    assign w_az     = w_az_rnd[TURN_W-1 -: ANGLE_WIDTH];
    assign w_el     = i_el_zero ? '0 : w_el_rnd[TURN_W-1 -: ANGLE_WIDTH];

    // bounds shrunk by half the scan size, wrapping
    assign w_hw    = ANGLE_WIDTH'(i_swid >> 1);
    assign w_hh    = ANGLE_WIDTH'(i_shgt >> 1);
    assign w_az_lo = i_az_left  + w_hw;
    assign w_az_hi = i_az_right - w_hw;
    assign w_el_lo = i_el_lower + w_hh;
    assign w_el_hi = i_el_upper - w_hh;

    // when bounds cross, a value below the lower bound takes it, any other the upper bound
    always_comb begin
        n_az = w_az;
        if (w_az < w_az_lo) begin
            n_az = w_az_lo;
        end else if (w_az > w_az_hi) begin
            n_az = w_az_hi;
        end
        n_el = w_el;
        if (w_el < w_el_lo) begin
            n_el = w_el_lo;
        end else if (w_el > w_el_hi) begin
            n_el = w_el_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
        if (w_en) begin
            r_az <= n_az;
            r_el <= n_el;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.ref_azimuth   = r_az;
    assign o_out.ref_elevation = r_el;

endmodule

>>> rtl/antenna_look_angle_to_point.sv
// Look angle toward a configured point of interest.
// Input channel i_in carries one item per pointing request: platform north,
// east and down position, sine and cosine of heading (q2.14) and the scan
// width and height. Output channel o_out returns one item per request: the
// limited reference azimuth and elevation as signed binary angles.
// Configuration: i_cfg_wen writes i_cfg_wdata to register i_cfg_index
// (point of interest north, east, down, then azimuth left/right and
// elevation lower/upper limits); write only while no item is in flight.
// Throughput: one item per clock while o_out is ready. Depth: 4 +
// 2*CORDIC_STEPS register stages, one stage per rotation for each of the
// two vectoring passes of the cordic pipeline, plus offset, multiply, sum
// and limit stages.
// Reset clears every valid bit and loads the default limits; the point of
// interest resets to zero.
// When o_out stalls, each stage holds its item and empty stages keep
// filling, so i_in.ready only drops once the whole pipeline is full.
module antenna_look_angle_to_point #(
    parameter int POS_WIDTH    = 32,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    alp_in_if.sink                               i_in,
    alp_out_if.source                            o_out,
    input  logic                                 i_cfg_wen,
    input  logic [alp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [((POS_WIDTH > ANGLE_WIDTH) ? POS_WIDTH : ANGLE_WIDTH)-1:0] i_cfg_wdata
);
    import alp_pkg::*;

    localparam int N    = CORDIC_STEPS;
    localparam int SC_W = ANGLE_WIDTH - 1;
    localparam int SA_W = X_W + 2 * SC_W + 1;
    localparam int SE_W = TURN_W + 2 * SC_W + 1;

    // configuration registers
    logic signed [POS_WIDTH-1:0] r_poi_north, r_poi_east, r_poi_down;
    logic [ANGLE_WIDTH-1:0]      r_az_left, r_az_right, r_el_lower, r_el_upper;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poi_north <= '0;
            r_poi_east  <= '0;
            r_poi_down  <= '0;
            r_az_left   <= ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);
            r_az_right  <= ~(ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1));
            r_el_lower  <= -(ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2));
            r_el_upper  <= ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                REG_POI_NORTH: r_poi_north <= i_cfg_wdata[POS_WIDTH-1:0];
                REG_POI_EAST:  r_poi_east  <= i_cfg_wdata[POS_WIDTH-1:0];
                REG_POI_DOWN:  r_poi_down  <= i_cfg_wdata[POS_WIDTH-1:0];
                REG_AZ_LEFT:   r_az_left   <= i_cfg_wdata[ANGLE_WIDTH-1:0];
                REG_AZ_RIGHT:  r_az_right  <= i_cfg_wdata[ANGLE_WIDTH-1:0];
                REG_EL_LOWER:  r_el_lower  <= i_cfg_wdata[ANGLE_WIDTH-1:0];
                REG_EL_UPPER:  r_el_upper  <= i_cfg_wdata[ANGLE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage boundaries of the two cordic passes
    logic              w_av [0:N];
    logic              w_ar [0:N];
    t_vec              w_ax [0:N];
    t_vec              w_ay [0:N];
    t_turn             w_aa [0:N];
    logic [SA_W-1:0]   w_as [0:N];
    logic              w_ev [0:N];
    logic              w_er [0:N];
    t_vec              w_ex [0:N];
    t_vec              w_ey [0:N];
    t_turn             w_ea [0:N];
    logic [SE_W-1:0]   w_es [0:N];

    logic signed [X_W-1:0] w_h, w_fh;
    logic                  w_az_zero, w_faz_zero, w_el_zero;
    logic [SC_W-1:0]       w_sw, w_sh, w_fsw, w_fsh;
    t_turn                 w_az_turns;

    // offsets, products, rotation into the heading frame
    alp_front #(
        .POS_WIDTH   (POS_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_poi_north (r_poi_north),
        .i_poi_east  (r_poi_east),
        .i_poi_down  (r_poi_down),
        .o_valid     (w_av[0]),
        .i_ready     (w_ar[0]),
        .o_x         (w_ax[0]),
        .o_y         (w_ay[0]),
        .o_ang       (w_aa[0]),
        .o_h         (w_fh),
        .o_az_zero   (w_faz_zero),
        .o_swid      (w_fsw),
        .o_shgt      (w_fsh)
    );

    assign w_as[0] = {w_fh, w_faz_zero, w_fsw, w_fsh};

    // azimuth pass
    for (genvar g = 0; g < N; g++) begin : g_az
        alp_cordic_stage #(
            .STEP   (g),
            .SIDE_W (SA_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_av[g]),
            .o_ready (w_ar[g]),
            .i_x     (w_ax[g]),
            .i_y     (w_ay[g]),
            .i_ang   (w_aa[g]),
            .i_side  (w_as[g]),
            .o_valid (w_av[g+1]),
            .i_ready (w_ar[g+1]),
            .o_x     (w_ax[g+1]),
            .o_y     (w_ay[g+1]),
            .o_ang   (w_aa[g+1]),
            .o_side  (w_as[g+1])
        );
    end

    // hand over range and height to the elevation pass
    assign {w_h, w_az_zero, w_sw, w_sh} = w_as[N];
    assign w_az_turns = w_az_zero ? '0 : w_aa[N];
    assign w_el_zero  = (w_ax[N] == '0) && (w_h == '0);
    assign w_ev[0]    = w_av[N];
    assign w_ar[N]    = w_er[0];
    assign w_ex[0]    = w_ax[N];
    assign w_ey[0]    = CW'(w_h);
    assign w_ea[0]    = '0;
    assign w_es[0]    = {w_az_turns, w_el_zero, w_sw, w_sh};

    // elevation pass
    for (genvar g = 0; g < N; g++) begin : g_el
        alp_cordic_stage #(
            .STEP   (g),
            .SIDE_W (SE_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_ev[g]),
            .o_ready (w_er[g]),
            .i_x     (w_ex[g]),
            .i_y     (w_ey[g]),
            .i_ang   (w_ea[g]),
            .i_side  (w_es[g]),
            .o_valid (w_ev[g+1]),
            .i_ready (w_er[g+1]),
            .o_x     (w_ex[g+1]),
            .o_y     (w_ey[g+1]),
            .o_ang   (w_ea[g+1]),
            .o_side  (w_es[g+1])
        );
    end

    t_turn           w_laz;
    logic            w_lel_zero;
    logic [SC_W-1:0] w_lsw, w_lsh;

    assign {w_laz, w_lel_zero, w_lsw, w_lsh} = w_es[N];

    // rounding, limits, output register
    alp_limit #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_limit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_ev[N]),
        .o_ready    (w_er[N]),
        .i_az_turns (w_laz),
        .i_el_turns (w_ea[N]),
        .i_el_zero  (w_lel_zero),
        .i_swid     (w_lsw),
        .i_shgt     (w_lsh),
        .i_az_left  (r_az_left),
        .i_az_right (r_az_right),
        .i_el_lower (r_el_lower),
        .i_el_upper (r_el_upper),
        .o_out      (o_out)
    );

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // an open output drains every stage, so the input is open too
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("input stalled while output is open");

    // the handover between passes keeps the ready chain closed
    a_pass_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_er[0] |-> w_ar[0])
        else $error("azimuth pass stalled while elevation pass is open");

endmodule

>>> tb/alp_tb_pkg.sv
package alp_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    // one pointing request as the stimulus side sees it
    typedef struct packed {
        logic signed [31:0] own_north;
        logic signed [31:0] own_east;
        logic signed [31:0] own_down;
        logic signed [15:0] heading_sine;
        logic signed [15:0] heading_cosine;
        logic [14:0]        scan_width;
        logic [14:0]        scan_height;
    } t_request;

    typedef struct packed {
        logic signed [15:0] azimuth;
        logic signed [15:0] elevation;
    } t_look;

    // register contents shared by stimulus and checker
    typedef struct packed {
        logic signed [31:0] poi_north;
        logic signed [31:0] poi_east;
        logic signed [31:0] poi_down;
        logic signed [15:0] az_left;
        logic signed [15:0] az_right;
        logic signed [15:0] el_lower;
        logic signed [15:0] el_upper;
    } t_limits;
endpackage

>>> tb/alp_look_checker.sv
module alp_look_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    alp_in_if               i_in,
    alp_out_if              i_out,
    input  alp_tb_pkg::t_limits i_cfg,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import alp_pkg::*;
    import alp_tb_pkg::*;

    t_look expected_looks[$];

    // cordic vectoring, returns accumulated turn, updates x in place
    function automatic logic [31:0] vector_turns(inout logic signed [63:0] x,
                                                 input logic signed [63:0] y0,
                                                 input logic [31:0] start);
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [31:0] acc;
        y = y0;
        acc = start;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; acc = acc + atan_turn(i);
            end else begin
                x = x - dx; y = y + dy; acc = acc - atan_turn(i);
            end
        end
        return acc;
    endfunction

    function automatic logic signed [15:0] round_turn(input logic [31:0] t);
        logic [31:0] r;
        r = t + 32'h8000;
        return r[31:16];
    endfunction

    function automatic logic signed [15:0] clamp_angle(input logic signed [15:0] a,
            input logic [15:0] lo_reg, input logic [15:0] hi_reg, input logic [14:0] size);
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        lo = lo_reg + (size >> 1);
        hi = hi_reg - (size >> 1);
        if (a < lo) return lo;
        if (a > hi) return hi;
        return a;
    endfunction

    // expected look angles for one request
    function automatic t_look predict_look(input t_request rq, input t_limits c);
        logic signed [63:0] dn;
        logic signed [63:0] de;
        logic signed [63:0] dd;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] h;
        logic signed [15:0] az;
        logic signed [15:0] el;
        logic [31:0] start;
        t_look r;
        dn = 64'(c.poi_north) - 64'(rq.own_north);
        de = 64'(c.poi_east) - 64'(rq.own_east);
        dd = 64'(c.poi_down) - 64'(rq.own_down);
        x = dn * 64'(rq.heading_cosine) + de * 64'(rq.heading_sine);
        y = de * 64'(rq.heading_cosine) - dn * 64'(rq.heading_sine);
        h = -dd * 64'sd26981;
        start = '0;
        if (x == 0 && y == 0) begin
            az = '0;
        end else begin
            if (x < 0) begin
                x = -x; y = -y; start = 32'h80000000;
            end
            az = round_turn(vector_turns(x, y, start));
        end
        if (x == 0 && h == 0) el = '0;
        else el = round_turn(vector_turns(x, h, 32'h0));
        r.azimuth = clamp_angle(az, c.az_left, c.az_right, rq.scan_width);
        r.elevation = clamp_angle(el, c.el_lower, c.el_upper, rq.scan_height);
        return r;
    endfunction

    assign o_pending = expected_looks.size();

    // predict on accepted requests, compare accepted results
    always @(posedge i_clk) begin
        t_request rq;
        t_look want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                rq.own_north = i_in.own_north;
                rq.own_east = i_in.own_east;
                rq.own_down = i_in.own_down;
                rq.heading_sine = i_in.heading_sine;
                rq.heading_cosine = i_in.heading_cosine;
                rq.scan_width = i_in.scan_width;
                rq.scan_height = i_in.scan_height;
                expected_looks.push_back(predict_look(rq, i_cfg));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_looks.size() == 0) begin
                    $display("%0t: unexpected item az %0d el %0d", $time,
                             i_out.ref_azimuth, i_out.ref_elevation);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_looks.pop_front();
                    if (want.azimuth !== i_out.ref_azimuth ||
                        want.elevation !== i_out.ref_elevation) begin
                        $display("%0t: expected az %0d el %0d, got az %0d el %0d", $time,
                                 want.azimuth, want.elevation,
                                 i_out.ref_azimuth, i_out.ref_elevation);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/tb_antenna_look_angle_to_point.sv
module tb_antenna_look_angle_to_point;
    timeunit 1ns;
    timeprecision 1ps;
    import alp_pkg::*;
    import alp_tb_pkg::*;

    localparam int LATENCY = 36;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wen;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_wdata;
    t_limits cfg_shadow;
    int fail_count;
    int pending;
    int cycle_count;
    int sink_stall;

    alp_in_if  #(.POS_WIDTH(32), .ANGLE_WIDTH(16)) req_ch ();
    alp_out_if #(.ANGLE_WIDTH(16)) look_ch ();

    antenna_look_angle_to_point dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_ch.sink), .o_out(look_ch.source),
        .i_cfg_wen(i_cfg_wen), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    alp_look_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_ch), .i_out(look_ch),
        .i_cfg(cfg_shadow), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side stalls at random, with calm stretches
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            look_ch.ready <= 1'b0;
        end else if (look_ch.valid && look_ch.ready) begin
            if (($urandom & 32'h7F) < 40) sink_stall <= $urandom_range(0, 10);
            look_ch.ready <= 1'b1;
        end else begin
            look_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_wen <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            REG_POI_NORTH: cfg_shadow.poi_north = val;
            REG_POI_EAST:  cfg_shadow.poi_east = val;
            REG_POI_DOWN:  cfg_shadow.poi_down = val;
            REG_AZ_LEFT:   cfg_shadow.az_left = val[15:0];
            REG_AZ_RIGHT:  cfg_shadow.az_right = val[15:0];
            REG_EL_LOWER:  cfg_shadow.el_lower = val[15:0];
            default:       cfg_shadow.el_upper = val[15:0];
        endcase
    endtask

    task automatic load_limits(input t_limits c);
        write_reg(REG_POI_NORTH, c.poi_north);
        write_reg(REG_POI_EAST, c.poi_east);
        write_reg(REG_POI_DOWN, c.poi_down);
        write_reg(REG_AZ_LEFT, 32'(c.az_left));
        write_reg(REG_AZ_RIGHT, 32'(c.az_right));
        write_reg(REG_EL_LOWER, 32'(c.el_lower));
        write_reg(REG_EL_UPPER, 32'(c.el_upper));
    endtask

    // drive one request, with a random gap first when gaps is set
    task automatic send_request(input t_request rq, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.own_north <= rq.own_north;
        req_ch.own_east <= rq.own_east;
        req_ch.own_down <= rq.own_down;
        req_ch.heading_sine <= rq.heading_sine;
        req_ch.heading_cosine <= rq.heading_cosine;
        req_ch.scan_width <= rq.scan_width;
        req_ch.scan_height <= rq.scan_height;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain_results;
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending > 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_pos(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $signed($urandom_range(0, 200000)) - 100000;
        endcase
    endfunction

    function automatic t_request rand_request(input int mode);
        t_request rq;
        int ang;
        rq.own_north = rand_pos(mode);
        rq.own_east = rand_pos(mode);
        rq.own_down = rand_pos(mode);
        if ($urandom_range(0, 3) == 0) begin
            rq.heading_sine = $signed($urandom_range(0, 32768)) - 16384;
            rq.heading_cosine = $signed($urandom_range(0, 32768)) - 16384;
        end else begin
            ang = $urandom_range(0, 7);
            rq.heading_sine = $rtoi(16384.0 * $sin(ang * 0.785398163));
            rq.heading_cosine = $rtoi(16384.0 * $cos(ang * 0.785398163));
        end
        rq.scan_width = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 4000);
        rq.scan_height = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 4000);
        return rq;
    endfunction

    function automatic t_limits rand_limits;
        t_limits c;
        c.poi_north = rand_pos($urandom_range(0, 2));
        c.poi_east = rand_pos($urandom_range(0, 2));
        c.poi_down = rand_pos($urandom_range(0, 2));
        c.az_left = $urandom;
        c.az_right = $urandom;
        c.el_lower = $urandom;
        c.el_upper = $urandom;
        return c;
    endfunction

    initial begin
        t_request rq;
        t_limits c;
        cycle_count = 0;
        sink_stall = 0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.own_north = '0;
        req_ch.own_east = '0;
        req_ch.own_down = '0;
        req_ch.heading_sine = '0;
        req_ch.heading_cosine = '0;
        req_ch.scan_width = '0;
        req_ch.scan_height = '0;
        look_ch.ready = 1'b0;
        cfg_shadow = '{0, 0, 0, -16'sd32768, 16'sd32767, -16'sd16384, 16'sd16384};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset limits, zero vector, rear hemisphere, field extremes
        rq = '0;
        send_request(rq, 1'b0);
        rq.heading_cosine = 16'sd16384;
        rq.own_north = 32'sd1000;
        send_request(rq, 1'b0);
        rq.own_north = -32'sd1000;
        send_request(rq, 1'b0);
        rq.own_east = 32'sd500; rq.own_down = -32'sd300;
        send_request(rq, 1'b0);
        rq = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, -16'sd16384, 16'sd16384,
               15'h7FFF, 15'h7FFF};
        send_request(rq, 1'b0);
        rq = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'sd16384, -16'sd16384,
               15'h0, 15'h0};
        send_request(rq, 1'b0);
        rq = '{32'h00000000, 32'h00000000, 32'h7FFFFFFF, 16'sd0, 16'sd0, 15'h1, 15'h4000};
        send_request(rq, 1'b0);
        drain_results();

        // extreme registers, then narrow and crossed limits
        load_limits('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                      16'sh7FFF, -16'sd32768, 16'sh7FFF, -16'sd32768});
        for (int i = 0; i < 6; i++) send_request(rand_request(i % 3), 1'b0);
        drain_results();
        load_limits('{32'sd0, 32'sd0, 32'sd0, -16'sd4000, 16'sd4000, -16'sd1000, 16'sd3000});
        for (int i = 0; i < 8; i++) send_request(rand_request(1), 1'b1);
        drain_results();

        // random phases with a fresh setting each
        for (int ph = 0; ph < 9; ph++) begin
            c = rand_limits();
            if (ph % 3 == 0) c.az_left = -16'sd32768;
            load_limits(c);
            for (int i = 0; i < 50; i++) send_request(rand_request($urandom_range(0, 2)),
                                                      (ph % 4) != 1);
            drain_results();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
